// ===== rtl/cmma_pkg.sv =====
`timescale 1ns / 1ps

package cmma_pkg;

  localparam int OP_W       = 2;
  localparam int ADDR_W     = 24;
  localparam int DATA_W     = 8;
  localparam int RAM_SIZE_W = 14;
  localparam int ROM_SIZE_W = 19;
  localparam int SIZE_W     = ROM_SIZE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ROM_SIZE_W;

  localparam int RAM_DEPTH_DEF    = 8192;
  localparam int ROM_DEPTH_DEF    = 262144;
  localparam int ADDRESS_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROM_SIZE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] idx;
  } fold_res_t;

endpackage

// ===== rtl/cmma_if.sv =====
`timescale 1ns / 1ps

interface cmma_in_if import cmma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, opcode, address, write_data, input ready);
  modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

interface cmma_out_if import cmma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== rtl/character_memory_mirrored_access_top.sv =====
`timescale 1ns / 1ps

// Character memory with address mirroring for RAM and ROM sizes that need not
// be powers of two. Program ram_size and rom_size through the write port while
// idle. A preload, an unused opcode, or a write with no RAM present needs no
// fold and leaves the block idle. A read with RAM or ROM present, or a RAM
// write, folds the address one bit per cycle in the mirroring unit, highest bit
// first, and stops once the address falls below the remaining size or the bits
// run out; the RAM or ROM port is accessed as the fold ends. A read then loads
// its byte from the out state when the output register is free. The result
// sits in an output register, so the next item is taken while it waits.
// Memory contents are undefined until written; no clearing pass runs at reset.

module character_memory_mirrored_access_top import cmma_pkg::*; #(
  parameter int RAM_DEPTH    = RAM_DEPTH_DEF,
  parameter int ROM_DEPTH    = ROM_DEPTH_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cmma_in_if.sink               in_ch,
  cmma_out_if.source            out_ch
);

  localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int ROM_AW = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam logic [ADDR_W:0] RAM_LIM = (ADDR_W+1)'(RAM_DEPTH);
  localparam logic [ADDR_W:0] ROM_LIM = (ADDR_W+1)'(ROM_DEPTH);

  logic [RAM_SIZE_W-1:0] ram_size;
  logic [ROM_SIZE_W-1:0] rom_size;

  state_t            state;
  state_t            state_next;
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] data_q;
  logic              use_rom;
  logic              zero_q;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;

  logic              acc;
  logic              has_ram;
  logic              has_rom;
  logic              need_fold;
  logic [SIZE_W-1:0] fold_size;
  fold_res_t         fold_res;
  logic [ADDR_W:0]   idx_ext;
  logic              ram_ok;
  logic              rom_ok;
  logic              idx_ok;
  logic              pre_ok;
  logic              preload_go;
  logic              out_load;

  logic              ram_en;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;
  logic              rom_en;
  logic              rom_we;
  logic [ROM_AW-1:0] rom_addr;
  logic [DATA_W-1:0] rom_wdata;
  logic [DATA_W-1:0] rom_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_size <= '0;
      rom_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAM_SIZE: ram_size <= cfg_data[RAM_SIZE_W-1:0];
        REG_ROM_SIZE: rom_size <= cfg_data[ROM_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign acc       = in_ch.valid && in_ch.ready;
  assign has_ram   = ram_size != '0;
  assign has_rom   = rom_size != '0;
  assign need_fold = ((in_ch.opcode == OP_READ) && (has_ram || has_rom)) ||
                     ((in_ch.opcode == OP_WRITE) && has_ram);
  assign fold_size = has_ram ? SIZE_W'(ram_size) : rom_size;

  cmma_fold #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_fold (
    .clk  (clk),
    .rst  (rst),
    .start(acc && need_fold),
    .addr (in_ch.address),
    .size (fold_size),
    .res  (fold_res)
  );

  assign idx_ext    = (ADDR_W+1)'(fold_res.idx);
  assign ram_ok     = idx_ext < RAM_LIM;
  assign rom_ok     = idx_ext < ROM_LIM;
  assign idx_ok     = use_rom ? rom_ok : ram_ok;
  assign pre_ok     = {1'b0, in_ch.address} < ROM_LIM;
  assign preload_go = acc && (in_ch.opcode == OP_PRELOAD) && pre_ok;
  assign out_load   = (state == ST_OUT) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (need_fold) begin
            state_next = ST_FOLD;
          end else if (in_ch.opcode == OP_READ) begin
            state_next = ST_OUT;
          end
        end
      end
      ST_FOLD: begin
        if (fold_res.done) begin
          state_next = (op_q == OP_READ) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state == ST_IDLE;
    ram_en      = (state == ST_FOLD) && fold_res.done && !use_rom && ram_ok;
    ram_we      = op_q == OP_WRITE;
    ram_addr    = idx_ext[RAM_AW-1:0];
    rom_en      = ((state == ST_FOLD) && fold_res.done && use_rom && rom_ok) || preload_go;
    rom_we      = preload_go;
    rom_addr    = preload_go ? in_ch.address[ROM_AW-1:0] : idx_ext[ROM_AW-1:0];
    rom_wdata   = in_ch.write_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_q    <= in_ch.opcode;
      data_q  <= in_ch.write_data;
      use_rom <= !has_ram;
      zero_q  <= !need_fold;
    end else if ((state == ST_FOLD) && fold_res.done) begin
      zero_q <= !idx_ok;
    end
  end

  cmma_ram #(
    .DEPTH(RAM_DEPTH),
    .AW   (RAM_AW)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(data_q),
    .rdata(ram_rdata)
  );

  cmma_ram #(
    .DEPTH(ROM_DEPTH),
    .AW   (ROM_AW)
  ) u_rom (
    .clk  (clk),
    .en   (rom_en),
    .we   (rom_we),
    .addr (rom_addr),
    .wdata(rom_wdata),
    .rdata(rom_rdata)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= zero_q ? '0 : (use_rom ? rom_rdata : ram_rdata);
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.read_data = out_data;

  a_preload_single: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_ch.opcode == OP_PRELOAD)) |=> (state == ST_IDLE))
    else $error("preload did not complete in one cycle");

  a_fold_in_state: assert property (@(posedge clk) disable iff (rst)
    fold_res.done |-> (state == ST_FOLD))
    else $error("fold finished outside the fold state");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("result raised without a load");

endmodule

// ===== rtl/cmma_ram.sv =====
`timescale 1ns / 1ps

module cmma_ram import cmma_pkg::*; #(
  parameter int DEPTH = RAM_DEPTH_DEF,
  parameter int AW    = 13
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/cmma_fold.sv =====
`timescale 1ns / 1ps

module cmma_fold import cmma_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] addr,
  input  logic [SIZE_W-1:0] size,
  output fold_res_t         res
);

  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] TOP_BIT   = ADDR_W'(64'd1 << (ADDRESS_BITS - 1));

  logic              busy;
  logic [ADDR_W-1:0] a;
  logic [SIZE_W-1:0] s;
  logic [SIZE_W-1:0] base;
  logic [ADDR_W-1:0] bitm;
  logic [ADDR_W-1:0] s_ext;
  logic              step_done;

  assign s_ext     = ADDR_W'(s);
  assign step_done = (a < s_ext) || (bitm == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step_done) begin
      busy <= 1'b0;
    end
  end

  // strip one address bit per cycle, highest first
  always_ff @(posedge clk) begin
    if (start) begin
      a    <= addr & ADDR_MASK;
      s    <= size;
      base <= '0;
      bitm <= TOP_BIT;
    end else if (busy && !step_done) begin
      if ((a & bitm) != '0) begin
        a <= a & ~bitm;
        if (s_ext > bitm) begin
          s    <= s - bitm[SIZE_W-1:0];
          base <= base + bitm[SIZE_W-1:0];
        end
      end
      bitm <= bitm >> 1;
    end
  end

  assign res.done = busy && step_done;
  assign res.idx  = base + a[SIZE_W-1:0];

endmodule
